// ===== rtl/lpg_pkg.sv =====
`default_nettype none
package lpg_pkg;

	// Default generator width.
	localparam int LcgBitsDefault = 13;

	// Generator constants.
	localparam int unsigned LcgMul = 845;
	localparam int unsigned LcgAdd = 2625;

	// Rejected pairs allowed per request before the zero pair is taken.
	localparam int unsigned MaxTries = 4096;

	// ln 2 in Q0.32.
	localparam logic [31:0] Ln2Q32 = 32'd2977044472;

	// Configuration register indexes.
	localparam logic [1:0] RegSeed   = 2'd0;
	localparam logic [1:0] RegMean   = 2'd1;
	localparam logic [1:0] RegStdDev = 2'd2;

	// Operand width of the shared multiplier.
	localparam int MulW = 32;

endpackage
`default_nettype wire

// ===== rtl/lcg_polar_gaussian_generator.sv =====
// A request walks the pair draw, the squares, the check, up to 24 normalize steps, the
// 24-step logarithm, the 54-step divider, the 27-step square root and two multiplies per
// sample; each rejected pair draws again. The x sample comes first, then the y sample. One
// shared 32x32 multiplier serves the squares, the logarithm, the ln 2 scaling and the samples.
// One request at a time: a new request is taken only in idle, and in_stall is high otherwise.
// Reset clears the sequencer, the output valid flag and the generator, mean = 0, std_dev = 1.0.
`default_nettype none
module lcg_polar_gaussian_generator
	import lpg_pkg::*;
#(
	parameter int LCG_BITS = LcgBitsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               generate_req,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      sample,
	output logic                    last,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);

	localparam int Dn = (LCG_BITS > 13) ? LCG_BITS - 13 : 0;
	localparam int Up = (LCG_BITS < 13) ? 13 - LCG_BITS : 0;
	localparam int LinW = LCG_BITS + 12;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_DRAWX = 14'b00000000000010,
		S_DRAWY = 14'b00000000000100,
		S_SQX   = 14'b00000000001000,
		S_SQY   = 14'b00000000010000,
		S_CHECK = 14'b00000000100000,
		S_NORM  = 14'b00000001000000,
		S_LOG   = 14'b00000010000000,
		S_LN    = 14'b00000100000000,
		S_DIV   = 14'b00001000000000,
		S_SQRT  = 14'b00010000000000,
		S_MUL1  = 14'b00100000000000,
		S_MUL2  = 14'b01000000000000,
		S_EMIT  = 14'b10000000000000
	} state_t;

	state_t                 state_q;
	logic [LCG_BITS-1:0]    lcg_q;
	logic signed [23:0]     mean_q;
	logic [15:0]            std_q;
	logic signed [13:0]     ux_q, uy_q;
	logic [25:0]            acc_q;
	logic [11:0]            tries_q;
	logic [23:0]            m_q;
	logic [4:0]             e_q;
	logic [30:0]            mm_q;
	logic [23:0]            frac_q;
	logic [5:0]             cnt_q;
	logic [53:0]            dvd_q;
	logic [23:0]            rem_q;
	logic [53:0]            v_q, res_q, bit_q;
	logic [26:0]            f_q;
	logic                   sel_y_q;
	logic [28:0]            p_q;
	logic [55:0]            mag_q;
	logic                   out_valid_q;
	logic signed [31:0]     sample_q;
	logic                   last_q;

	// Next generator value and its uniform in Q0.12.
	logic [LinW-1:0]        lin;
	logic [LCG_BITS-1:0]    lcg_next;
	logic [LinW-1:0]        scaled;
	logic signed [13:0]     u_next;

	assign lin = LinW'(lcg_q) * LinW'(LcgMul) + LinW'(LcgAdd);
	assign lcg_next = lin[LCG_BITS-1:0];
	assign scaled = (LinW'(lcg_next) >> Dn) << Up;
	assign u_next = $signed({1'b0, scaled[12:0]}) - 14'sd4096;

	// Magnitudes of the pair.
	logic [12:0] ax, ay, au;
	logic [13:0] ax_w, ay_w;
	assign ax_w = ux_q[13] ? 14'(-ux_q) : 14'(ux_q);
	assign ay_w = uy_q[13] ? 14'(-uy_q) : 14'(uy_q);
	assign ax = ax_w[12:0] | {ax_w[13], 12'b0};
	assign ay = ay_w[12:0] | {ay_w[13], 12'b0};
	assign au = sel_y_q ? ay : ax;

	// Exponent and fraction of log2(S) turned into 24 - log2(S).
	logic [28:0] t_val;
	assign t_val = (29'(24) << 24) - ({e_q, 24'b0} + 29'(frac_q));

	// Shared multiplier operands.
	logic [MulW-1:0]   mul_a, mul_b;
	logic [2*MulW-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQX: begin
				mul_a = MulW'(ax);
				mul_b = MulW'(ax);
			end
			S_SQY: begin
				mul_a = MulW'(ay);
				mul_b = MulW'(ay);
			end
			S_LOG: begin
				mul_a = MulW'(mm_q);
				mul_b = MulW'(mm_q);
			end
			S_LN: begin
				mul_a = MulW'(t_val);
				mul_b = Ln2Q32;
			end
			S_MUL1: begin
				mul_a = MulW'(au);
				mul_b = MulW'(std_q);
			end
			S_MUL2: begin
				mul_a = MulW'(p_q);
				mul_b = MulW'(f_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	lpg_mul u_mul (
		.a(mul_a),
		.b(mul_b),
		.p(prod)
	);

	// One squaring step of the logarithm.
	logic [31:0] sq;
	assign sq = prod[61:30];

	// Rounded -ln s in Q.24.
	logic [63:0] ln_sum;
	assign ln_sum = prod + 64'h80000000;

	// Division step.
	logic [24:0] trial;
	logic        q_bit;
	assign trial = {rem_q, dvd_q[53]};
	assign q_bit = trial >= {1'b0, acc_q[23:0]};

	// Square root step.
	logic [53:0] rb;
	assign rb = res_q + bit_q;

	// Final rounding, sign, offset and saturation.
	logic [32:0]        r_mag;
	logic signed [35:0] v_sum;
	logic signed [31:0] v_sat;
	assign r_mag = 33'((57'(mag_q) + 57'(1 << 23)) >> 24);
	always_comb begin
		v_sum = (sel_y_q ? uy_q[13] : ux_q[13]) ? -$signed({3'b0, r_mag})
			: $signed({3'b0, r_mag});
		v_sum = v_sum + 36'(mean_q);
		if (v_sum > 36'sd2147483647) begin
			v_sat = 32'sh7fffffff;
		end else if (v_sum < -36'sd2147483648) begin
			v_sat = 32'sh80000000;
		end else begin
			v_sat = 32'(v_sum);
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign last = last_q;

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lcg_q <= '0;
			mean_q <= '0;
			std_q <= 16'd256;
			out_valid_q <= 1'b0;
			tries_q <= '0;
			cnt_q <= '0;
			sel_y_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					RegSeed:   lcg_q <= LCG_BITS'(cfg_data[12:0]);
					RegMean:   mean_q <= $signed(cfg_data);
					RegStdDev: std_q <= cfg_data[15:0];
					default:   ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && generate_req) begin
						tries_q <= '0;
						state_q <= S_DRAWX;
					end
				end
				S_DRAWX: begin
					lcg_q <= lcg_next;
					state_q <= S_DRAWY;
				end
				S_DRAWY: begin
					lcg_q <= lcg_next;
					state_q <= S_SQX;
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_CHECK;
				S_CHECK: begin
					if (acc_q != '0 && acc_q < 26'(1 << 24)) begin
						state_q <= S_NORM;
					end else if (tries_q == 12'(MaxTries - 1)) begin
						sel_y_q <= 1'b0;
						state_q <= S_MUL1;
					end else begin
						tries_q <= tries_q + 12'd1;
						state_q <= S_DRAWX;
					end
				end
				S_NORM: begin
					if (m_q[23]) begin
						cnt_q <= 6'd23;
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= S_LN;
					end
				end
				S_LN: begin
					cnt_q <= 6'd53;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						cnt_q <= 6'd26;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						sel_y_q <= 1'b0;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_EMIT;
				S_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						if (sel_y_q) begin
							state_q <= S_IDLE;
						end else begin
							sel_y_q <= 1'b1;
							state_q <= S_MUL1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_DRAWX: ux_q <= u_next;
			S_DRAWY: uy_q <= u_next;
			S_SQX: acc_q <= prod[25:0];
			S_SQY: acc_q <= acc_q + prod[25:0];
			S_CHECK: begin
				m_q <= acc_q[23:0];
				e_q <= 5'd23;
				frac_q <= '0;
				if (!(acc_q != '0 && acc_q < 26'(1 << 24))
						&& tries_q == 12'(MaxTries - 1)) begin
					ux_q <= '0;
					uy_q <= '0;
					f_q <= '0;
				end
			end
			S_NORM: begin
				if (m_q[23]) begin
					mm_q <= {m_q, 7'b0};
				end else begin
					m_q <= {m_q[22:0], 1'b0};
					e_q <= e_q - 5'd1;
				end
			end
			S_LOG: begin
				mm_q <= sq[31] ? sq[31:1] : sq[30:0];
				frac_q <= {frac_q[22:0], sq[31]};
			end
			S_LN: begin
				dvd_q <= {ln_sum[60:32], 25'b0};
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= q_bit ? 24'(trial - {1'b0, acc_q[23:0]}) : trial[23:0];
				dvd_q <= {dvd_q[52:0], q_bit};
				if (cnt_q == '0) begin
					v_q <= {dvd_q[52:0], q_bit};
					res_q <= '0;
					bit_q <= 54'(1) << 52;
				end
			end
			S_SQRT: begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (cnt_q == '0) begin
					f_q <= (v_q >= rb) ? 27'((res_q >> 1) + bit_q) : 27'(res_q >> 1);
				end
			end
			S_MUL1: p_q <= prod[28:0];
			S_MUL2: mag_q <= prod[55:0];
			S_EMIT: begin
				if (!out_valid_q) begin
					sample_q <= v_sat;
					last_q <= sel_y_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/lpg_mul.sv =====
`default_nettype none
module lpg_mul
	import lpg_pkg::*;
(
	input  wire logic [MulW-1:0]   a,
	input  wire logic [MulW-1:0]   b,
	output logic      [2*MulW-1:0] p
);

	// Unsigned product shared by the multiplying steps of the sequencer.
	assign p = (2*MulW)'(a) * (2*MulW)'(b);

endmodule
`default_nettype wire
